[rtl/core/assert_macros.svh]
// Assertion macros for the checker file of the timer bank.
// No dependencies; expects signals named clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// An antecedent that implies a consequent sequence starting in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);

// An antecedent that implies a condition in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/tcb_pkg.sv]
// Shared types and codes of the countdown timer bank.
// No dependencies; used by every module of the block.
`default_nettype none

package tcb_pkg;

  localparam int OP_W    = 3;
  localparam int TIDX_W  = 3;
  localparam int TICK_W  = 16;
  localparam int KIND_W  = 2;
  localparam int MASK_W  = 8;

  localparam logic [OP_W-1:0] OP_SET   = 3'd0;
  localparam logic [OP_W-1:0] OP_STOP  = 3'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 3'd2;
  localparam logic [OP_W-1:0] OP_POLL  = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK  = 3'd4;

  localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STOP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TIDX_W-1:0] which;
    logic [TICK_W-1:0] remaining;
    logic              elapsed;
    logic              from_tick;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/tcb_count_mem.sv]
// Tick count store: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on tcb_pkg.
`default_nettype none

module tcb_count_mem #(
  parameter int TIMER_COUNT = 8,
  parameter int IDX_W       = 3
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       we,
  input  wire  [IDX_W-1:0]          waddr,
  input  wire  [tcb_pkg::TICK_W-1:0] wdata,
  input  wire  [IDX_W-1:0]          raddr,
  output logic [tcb_pkg::TICK_W-1:0] rdata
);
  import tcb_pkg::*;

  logic [TICK_W-1:0]      mem [TIMER_COUNT];
  logic [TIMER_COUNT-1:0] valid_r;
  logic [TICK_W-1:0]      rd_data_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      rd_vld_r <= valid_r[raddr];
    end
  end

  assign rdata = rd_vld_r ? rd_data_r : '0;

endmodule

`default_nettype wire

[rtl/core/tcb_seq.sv]
// Sequencer of the timer bank: decodes operations, walks the timers one per
// cycle through the shared decrement and zero compare, holds the active flags.
// Depends on tcb_pkg and drives tcb_count_mem.
`default_nettype none

module tcb_seq #(
  parameter int TIMER_COUNT = 8,
  parameter int IDX_W       = 3
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  input  wire  [tcb_pkg::OP_W-1:0]   op,
  input  wire  [tcb_pkg::TIDX_W-1:0] tidx,
  input  wire  [tcb_pkg::TICK_W-1:0] load,
  input  wire  [tcb_pkg::MASK_W-1:0] mask,
  output logic                       busy,
  output logic                       mem_we,
  output logic [IDX_W-1:0]           mem_waddr,
  output logic [tcb_pkg::TICK_W-1:0] mem_wdata,
  output logic [IDX_W-1:0]           mem_raddr,
  input  wire  [tcb_pkg::TICK_W-1:0] mem_rdata,
  output logic                       res_vld,
  output tcb_pkg::res_t              res
);
  import tcb_pkg::*;

  localparam int CNT_W = $clog2(TIMER_COUNT + 1);
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(TIMER_COUNT);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_REPLY = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic                   is_tick_r, is_tick_nxt;
  logic                   rep_stop_r, rep_stop_nxt;
  logic [TIDX_W-1:0]      rep_idx_r, rep_idx_nxt;
  logic [CNT_W-1:0]       scan_idx_r, scan_idx_nxt;
  logic                   proc_vld_r, proc_vld_nxt;
  logic [IDX_W-1:0]       proc_idx_r, proc_idx_nxt;
  logic                   pend_vld_r, pend_vld_nxt;
  logic [IDX_W-1:0]       pend_idx_r, pend_idx_nxt;
  logic [TIMER_COUNT-1:0] active_r, active_nxt;
  logic                   out_vld_r, out_vld_nxt;
  res_t                   out_r, out_nxt;

  logic accept;
  logic idx_ok;
  logic cnt_zero;
  logic isr_mode;
  logic hit;
  logic dec;

  assign accept   = start && (state_r == ST_IDLE);
  assign idx_ok   = 32'(tidx) < TIMER_COUNT;
  assign cnt_zero = (mem_rdata == '0);
  // Only the first eight timers have a mode bit.
  assign isr_mode = (32'(proc_idx_r) < 32'd8) && mask[3'(proc_idx_r)];
  assign hit      = proc_vld_r && cnt_zero && active_r[proc_idx_r] &&
                    (!is_tick_r || isr_mode);
  assign dec      = proc_vld_r && is_tick_r && !cnt_zero;

  always_comb begin
    state_nxt    = state_r;
    is_tick_nxt  = is_tick_r;
    rep_stop_nxt = rep_stop_r;
    rep_idx_nxt  = rep_idx_r;
    scan_idx_nxt = scan_idx_r;
    proc_vld_nxt = proc_vld_r;
    proc_idx_nxt = proc_idx_r;
    pend_vld_nxt = pend_vld_r;
    pend_idx_nxt = pend_idx_r;
    active_nxt   = active_r;
    out_vld_nxt  = 1'b0;
    out_nxt      = out_r;
    mem_we       = 1'b0;
    mem_waddr    = IDX_W'(tidx);
    mem_wdata    = load;
    mem_raddr    = (state_r == ST_SCAN) ? scan_idx_r[IDX_W-1:0] : IDX_W'(tidx);

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_SET: begin
              if (idx_ok) begin
                mem_we                    = 1'b1;
                active_nxt[IDX_W'(tidx)] = 1'b1;
              end
            end
            OP_STOP: begin
              if (idx_ok) begin
                active_nxt[IDX_W'(tidx)] = 1'b0;
                rep_stop_nxt              = 1'b1;
                rep_idx_nxt               = tidx;
                state_nxt                 = ST_REPLY;
              end
            end
            OP_QUERY: begin
              if (idx_ok) begin
                rep_stop_nxt = 1'b0;
                rep_idx_nxt  = tidx;
                state_nxt    = ST_REPLY;
              end
            end
            OP_POLL, OP_TICK: begin
              is_tick_nxt  = (op == OP_TICK);
              scan_idx_nxt = '0;
              proc_vld_nxt = 1'b0;
              pend_vld_nxt = 1'b0;
              state_nxt    = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_REPLY: begin
        out_vld_nxt       = 1'b1;
        out_nxt.kind      = rep_stop_r ? KIND_STOP : KIND_QUERY;
        out_nxt.which     = rep_idx_r;
        out_nxt.remaining = rep_stop_r ? mem_rdata : '0;
        out_nxt.elapsed   = !rep_stop_r && cnt_zero;
        out_nxt.from_tick = 1'b0;
        out_nxt.last      = 1'b1;
        state_nxt         = ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_idx_r != SCAN_END) begin
          proc_vld_nxt = 1'b1;
          proc_idx_nxt = scan_idx_r[IDX_W-1:0];
          scan_idx_nxt = scan_idx_r + 1'b1;
        end else begin
          proc_vld_nxt = 1'b0;
        end
        if (dec) begin
          mem_we    = 1'b1;
          mem_waddr = proc_idx_r;
          mem_wdata = mem_rdata - 1'b1;
        end
        // A new event pushes out the held one, which is then known not to be last.
        if (hit) begin
          active_nxt[proc_idx_r] = 1'b0;
          if (pend_vld_r) begin
            out_vld_nxt = 1'b1;
          end
          out_nxt.kind      = KIND_EXPIRY;
          out_nxt.which     = 3'(pend_idx_r);
          out_nxt.remaining = '0;
          out_nxt.elapsed   = 1'b0;
          out_nxt.from_tick = is_tick_r;
          out_nxt.last      = 1'b0;
          pend_vld_nxt      = 1'b1;
          pend_idx_nxt      = proc_idx_r;
        end
        if (!proc_vld_r && (scan_idx_r == SCAN_END)) begin
          out_vld_nxt       = pend_vld_r;
          out_nxt.kind      = KIND_EXPIRY;
          out_nxt.which     = 3'(pend_idx_r);
          out_nxt.remaining = '0;
          out_nxt.elapsed   = 1'b0;
          out_nxt.from_tick = is_tick_r;
          out_nxt.last      = 1'b1;
          pend_vld_nxt      = 1'b0;
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      proc_vld_r <= 1'b0;
      pend_vld_r <= 1'b0;
      active_r   <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      proc_vld_r <= proc_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      active_r   <= active_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_tick_r  <= is_tick_nxt;
    rep_stop_r <= rep_stop_nxt;
    rep_idx_r  <= rep_idx_nxt;
    scan_idx_r <= scan_idx_nxt;
    proc_idx_r <= proc_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_r      <= out_nxt;
  end

  assign busy    = (state_r != ST_IDLE);
  assign res_vld = out_vld_r;
  assign res     = out_r;

endmodule

`default_nettype wire

[rtl/core/countdown_timer_bank.sv]
// Top level of the countdown timer bank: configuration register, sequencer
// and tick count store. Depends on tcb_pkg, tcb_seq and tcb_count_mem.
`default_nettype none

// A bank of TIMER_COUNT countdown timers driven by single-item commands.
// An item is taken at a clock edge where start is high and busy is low.
// A set item returns nothing and does not raise busy. A stop or query item keeps
// busy high for one cycle; its reply is built in the reply state from the count
// read and is driven on the out_ ports from the sequencer's output register.
// A tick or poll item walks the timers in rising index order, one timer per
// cycle through the single read port of the count store and the one shared
// decrement and zero compare, and busy stays high for the whole walk; expiry
// events come out during and at the end of that
// walk. Every result is shown for exactly one cycle with out_valid high and
// must be taken then: the receiver cannot hold results off. out_last_result
// marks the final result of an item. Counts and active flags read as zero
// straight out of reset, with no clearing pass. The interrupt mode mask is
// written through the cfg_ channel, which is always ready; write it only
// while the bank is idle. Only timers 0 to 7 have a mode bit.

module countdown_timer_bank #(
  parameter int TIMER_COUNT = 8
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  output logic                        busy,
  input  wire  [tcb_pkg::OP_W-1:0]    in_operation,
  input  wire  [tcb_pkg::TIDX_W-1:0]  in_timer_index,
  input  wire  [tcb_pkg::TICK_W-1:0]  in_load_ticks,
  output logic                        out_valid,
  output logic [tcb_pkg::KIND_W-1:0]  out_result_kind,
  output logic [tcb_pkg::TIDX_W-1:0]  out_which_timer,
  output logic [tcb_pkg::TICK_W-1:0]  out_remaining_ticks,
  output logic                        out_has_elapsed,
  output logic                        out_from_tick,
  output logic                        out_last_result,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire  [tcb_pkg::MASK_W-1:0]  cfg_data
);
  import tcb_pkg::*;

  // Index width of the store; a bank of one timer still gets a one-bit address.
  localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

  logic [MASK_W-1:0] mask_r;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [TICK_W-1:0] mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  logic [TICK_W-1:0] mem_rdata;
  logic              res_vld;
  res_t              res;

  // The mask register accepts a write in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      mask_r <= cfg_data;
    end
  end

  tcb_seq #(
    .TIMER_COUNT (TIMER_COUNT),
    .IDX_W       (IDX_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .op        (in_operation),
    .tidx      (in_timer_index),
    .load      (in_load_ticks),
    .mask      (mask_r),
    .busy      (busy),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_vld   (res_vld),
    .res       (res)
  );

  tcb_count_mem #(
    .TIMER_COUNT (TIMER_COUNT),
    .IDX_W       (IDX_W)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The result item leaves straight from the sequencer's output register.
  assign out_valid           = res_vld;
  assign out_result_kind     = res.kind;
  assign out_which_timer     = res.which;
  assign out_remaining_ticks = res.remaining;
  assign out_has_elapsed     = res.elapsed;
  assign out_from_tick       = res.from_tick;
  assign out_last_result     = res.last;

endmodule

`default_nettype wire

[rtl/core/tcb_checker.sv]
// Port-level checks of the countdown timer bank and their bind to the top.
// Depends on tcb_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module tcb_checker #(
  parameter int TIMER_COUNT = 8
) (
  input wire                         clk,
  input wire                         rst_n,
  input wire                         start,
  input wire                         busy,
  input wire [tcb_pkg::OP_W-1:0]     in_operation,
  input wire [tcb_pkg::TIDX_W-1:0]   in_timer_index,
  input wire                         out_valid,
  input wire [tcb_pkg::KIND_W-1:0]   out_result_kind,
  input wire [tcb_pkg::TICK_W-1:0]   out_remaining_ticks,
  input wire                         out_has_elapsed,
  input wire                         out_last_result
);
  import tcb_pkg::*;

  logic query_taken;
  logic query_reply;
  logic expiry_ok;
  logic set_taken;

  assign query_taken = start && !busy && (in_operation == OP_QUERY) &&
                       (32'(in_timer_index) < TIMER_COUNT);
  assign query_reply = out_valid && out_last_result && (out_result_kind == KIND_QUERY);
  assign expiry_ok   = !(out_valid && (out_result_kind == KIND_EXPIRY)) ||
                       ((out_remaining_ticks == '0) && !out_has_elapsed);
  assign set_taken   = start && !busy && (in_operation == OP_SET);

  // A taken query item is answered through the reply state and the output register; the reply is its only result.
  `ASSERT_IMPLY(a_query_reply, query_taken, ##2 query_reply, "query reply missing or late")

  // Expiry events carry no count and no elapsed flag.
  `ASSERT_ALWAYS(a_expiry_clean, expiry_ok, "expiry event with stray payload")

  // More results are owed after one that is not last, so the bank is still working.
  `ASSERT_IMPLY(a_more_pending, out_valid && !out_last_result, busy, "non-final result while idle")

  // A set item finishes in the cycle it is taken, so the bank is free again at once.
  `ASSERT_NEXT(a_set_quick, set_taken, !busy, "set item left the bank busy")

endmodule

bind countdown_timer_bank tcb_checker #(
  .TIMER_COUNT (TIMER_COUNT)
) u_tcb_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .in_operation        (in_operation),
  .in_timer_index      (in_timer_index),
  .out_valid           (out_valid),
  .out_result_kind     (out_result_kind),
  .out_remaining_ticks (out_remaining_ticks),
  .out_has_elapsed     (out_has_elapsed),
  .out_last_result     (out_last_result)
);

`default_nettype wire

[tb/sv/tb_countdown_timer_bank.sv]
// Self-checking testbench for countdown_timer_bank: directed and random
// command items, with a cycle-free predictor of the timer bank state.
// Depends on tcb_pkg and the countdown_timer_bank RTL.

module tb_countdown_timer_bank;
  timeunit 1ns;
  timeprecision 1ps;

  import tcb_pkg::*;

  localparam int NUM_TIMERS    = 8;
  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 6;
  // Quiet cycles that settle() waits once the bank is idle, more than a tick or
  // poll walk keeps the bank busy, so no walk is still in flight.
  localparam int SETTLE_CYCLES = NUM_TIMERS + 4;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int SEGMENT_ITEMS = 55;
  localparam int MAX_REPORTS   = 60;

  // Operation codes that the bank ignores.
  localparam logic [OP_W-1:0] OP_UNUSED_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TIDX_W-1:0] idx;
    logic [TICK_W-1:0] load;
  } timer_cmd_t;

  // Every input starts at a known value.
  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                start          = 1'b0;
  logic [OP_W-1:0]     in_operation   = '0;
  logic [TIDX_W-1:0]   in_timer_index = '0;
  logic [TICK_W-1:0]   in_load_ticks  = '0;
  logic                cfg_valid      = 1'b0;
  logic [MASK_W-1:0]   cfg_data       = '0;

  logic                busy;
  logic                out_valid;
  logic [KIND_W-1:0]   out_result_kind;
  logic [TIDX_W-1:0]   out_which_timer;
  logic [TICK_W-1:0]   out_remaining_ticks;
  logic                out_has_elapsed;
  logic                out_from_tick;
  logic                out_last_result;
  logic                cfg_ready;

  // Items waiting to be driven, and results the bank still owes us.
  timer_cmd_t          pending_cmds[$];
  res_t                owed_results[$];

  // Predicted bank state: counts, armed flags and the interrupt mode mask.
  logic [TICK_W-1:0]   model_count [NUM_TIMERS];
  bit                  model_armed [NUM_TIMERS];
  logic [MASK_W-1:0]   model_isr_mask = '0;

  // Set by the monitor when the item on the in_ ports was taken at the last edge.
  logic                item_taken = 1'b0;
  // Percentage of cycles in which the driver holds back an item.
  int                  gap_pct = 0;
  int                  mismatch_count = 0;

  countdown_timer_bank #(
    .TIMER_COUNT(NUM_TIMERS)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_timer_index      (in_timer_index),
    .in_load_ticks       (in_load_ticks),
    .out_valid           (out_valid),
    .out_result_kind     (out_result_kind),
    .out_which_timer     (out_which_timer),
    .out_remaining_ticks (out_remaining_ticks),
    .out_has_elapsed     (out_has_elapsed),
    .out_from_tick       (out_from_tick),
    .out_last_result     (out_last_result),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Works out the results of one taken item and updates the predicted state.
  // Poll and tick walk the timers in rising index order, so their events are
  // queued in that order and the last one carries the last-result flag.
  function automatic void predict_timer_results(input timer_cmd_t c);
    res_t r;
    res_t batch[$];
    r = '0;
    case (c.op)
      OP_SET: begin
        model_count[c.idx] = c.load;
        model_armed[c.idx] = 1'b1;
      end
      OP_STOP: begin
        // Stop only disarms; the count keeps running down on later ticks.
        model_armed[c.idx] = 1'b0;
        r.kind      = KIND_STOP;
        r.which     = c.idx;
        r.remaining = model_count[c.idx];
        batch.push_back(r);
      end
      OP_QUERY: begin
        r.kind    = KIND_QUERY;
        r.which   = c.idx;
        r.elapsed = (model_count[c.idx] == '0);
        batch.push_back(r);
      end
      OP_POLL: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (model_count[i] == '0 && model_armed[i]) begin
            model_armed[i] = 1'b0;
            r = '0;
            r.kind  = KIND_EXPIRY;
            r.which = TIDX_W'(i);
            batch.push_back(r);
          end
        end
      end
      OP_TICK: begin
        // A count that reaches zero on this tick raises nothing yet; only a
        // timer already at zero, armed and in interrupt mode fires.
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (model_count[i] != '0) begin
            model_count[i] = model_count[i] - 1'b1;
          end else if (i < MASK_W && model_isr_mask[i] && model_armed[i]) begin
            model_armed[i] = 1'b0;
            r = '0;
            r.kind      = KIND_EXPIRY;
            r.which     = TIDX_W'(i);
            r.from_tick = 1'b1;
            batch.push_back(r);
          end
        end
      end
      default: begin
        // Unused operation codes leave the bank untouched.
      end
    endcase
    if (batch.size() != 0) begin
      batch[batch.size() - 1].last = 1'b1;
    end
    foreach (batch[k]) begin
      owed_results.push_back(batch[k]);
    end
  endfunction

  task automatic check_field(input string name, input logic [TICK_W-1:0] want,
                             input logic [TICK_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    end
  endtask

  // Monitor: samples at the rising edge, so it sees the values that were
  // stable through the cycle. Results are checked before the item taken at
  // the same edge is predicted, since that item's results come later.
  always @(posedge clk) begin : monitor
    res_t want;
    timer_cmd_t c;
    item_taken <= rst_n && start && !busy;
    if (rst_n) begin
      if (out_valid) begin
        if (owed_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t ns: result with nothing expected, expected none, actual kind %0d timer %0d",
                     $time, out_result_kind, out_which_timer);
          end
        end else begin
          want = owed_results.pop_front();
          check_field("result_kind", want.kind, out_result_kind);
          check_field("which_timer", want.which, out_which_timer);
          check_field("remaining_ticks", want.remaining, out_remaining_ticks);
          check_field("has_elapsed", want.elapsed, out_has_elapsed);
          check_field("from_tick", want.from_tick, out_from_tick);
          check_field("last_result", want.last, out_last_result);
        end
      end
      if (cfg_valid && cfg_ready) begin
        model_isr_mask = cfg_data;
      end
      if (start && !busy) begin
        c.op   = in_operation;
        c.idx  = in_timer_index;
        c.load = in_load_ticks;
        predict_timer_results(c);
      end
    end
  end

  // Driver: changes inputs at the falling edge. An item stays on the ports
  // until the bank takes it; between items it may hold back at random, and
  // while start is low the payload ports carry noise.
  always @(negedge clk) begin : driver
    timer_cmd_t c;
    if (rst_n && (!start || item_taken)) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= gap_pct) begin
        c = pending_cmds.pop_front();
        start          <= 1'b1;
        in_operation   <= c.op;
        in_timer_index <= c.idx;
        in_load_ticks  <= c.load;
      end else begin
        start          <= 1'b0;
        in_operation   <= OP_W'($urandom);
        in_timer_index <= TIDX_W'($urandom);
        in_load_ticks  <= TICK_W'($urandom);
      end
    end
  end

  function automatic void queue_cmd(input logic [OP_W-1:0] op, input int idx, input int load);
    timer_cmd_t c;
    c.op   = op;
    c.idx  = TIDX_W'(idx);
    c.load = TICK_W'(load);
    pending_cmds.push_back(c);
  endfunction

  // Mostly short counts so that timers actually expire; now and then a full
  // 16-bit value so every load bit is exercised.
  function automatic int pick_load();
    if ($urandom_range(7) == 0) begin
      return $urandom_range(65535);
    end
    return $urandom_range(4);
  endfunction

  // Waits until every item is taken and every owed result is in, then lets
  // a walk that produced nothing run out before anything else happens.
  task automatic settle();
    while (pending_cmds.size() != 0 || start || owed_results.size() != 0 || busy) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_isr_mask(input logic [MASK_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic. Most of it is well-formed: arm a few timers, tick them
  // down with stops, queries and polls mixed in, then perhaps poll. Some bursts arm every
  // timer near zero so one walk returns the full set of events, and the rest
  // is unconstrained noise, unused codes included.
  task automatic queue_random_items(input int target);
    int queued;
    int pick;
    queued = 0;
    while (queued < target) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        repeat ($urandom_range(1, 4)) begin
          queue_cmd(OP_SET, $urandom_range(7), pick_load());
          queued++;
        end
        repeat ($urandom_range(1, 6)) begin
          queue_cmd(OP_TICK, $urandom_range(7), $urandom_range(65535));
          queued++;
          case ($urandom_range(9))
            0: queue_cmd(OP_STOP, $urandom_range(7), $urandom_range(65535));
            1: queue_cmd(OP_QUERY, $urandom_range(7), $urandom_range(65535));
            2: queue_cmd(OP_POLL, $urandom_range(7), $urandom_range(65535));
            default: queued--;
          endcase
          queued++;
        end
        if ($urandom_range(1) == 1) begin
          queue_cmd(OP_POLL, $urandom_range(7), $urandom_range(65535));
          queued++;
        end
      end else if (pick < 70) begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          queue_cmd(OP_SET, i, $urandom_range(1));
        end
        queue_cmd($urandom_range(1) ? OP_TICK : OP_POLL, $urandom_range(7),
                  $urandom_range(65535));
        queued += NUM_TIMERS + 1;
      end else begin
        queue_cmd(OP_W'($urandom_range(7)), $urandom_range(7), $urandom_range(65535));
        queued++;
      end
    end
  endtask

  initial begin : stimulus
    for (int i = 0; i < NUM_TIMERS; i++) begin
      model_count[i] = '0;
      model_armed[i] = 1'b0;
    end

    // Synchronous reset, held once at the start of the run.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset mask: every timer in poll-only mode.
    gap_pct = 38;
    queue_cmd(OP_QUERY, 0, 0);          // count is zero straight out of reset
    queue_cmd(OP_POLL, 0, 0);           // nothing armed, no events
    queue_cmd(OP_TICK, 0, 0);
    queue_cmd(OP_SET, 0, 0);            // armed while already at zero
    queue_cmd(OP_SET, 1, 65535);        // largest count
    queue_cmd(OP_SET, 2, 1);            // reaches zero on the next tick
    queue_cmd(OP_SET, 7, 2);
    queue_cmd(OP_UNUSED_5, 3, 16'h1234);
    queue_cmd(OP_UNUSED_6, 5, 16'hFFFF);
    queue_cmd(OP_UNUSED_7, 7, 16'h0000);
    queue_cmd(OP_TICK, 7, 16'hFFFF);    // timer 2 reaches zero, no event yet
    queue_cmd(OP_QUERY, 2, 0);
    queue_cmd(OP_QUERY, 1, 0);
    queue_cmd(OP_STOP, 1, 0);
    queue_cmd(OP_TICK, 0, 0);           // stopped timer 1 still counts down
    queue_cmd(OP_STOP, 1, 0);
    queue_cmd(OP_POLL, 0, 0);           // events for timers 0, 2 and 7
    queue_cmd(OP_POLL, 0, 0);           // they are disarmed now

    // Every timer in interrupt mode: expiry comes from the tick.
    write_isr_mask(8'hFF);
    queue_cmd(OP_SET, 3, 0);
    queue_cmd(OP_SET, 4, 1);
    queue_cmd(OP_SET, 5, 16'hAAAA);
    queue_cmd(OP_SET, 6, 16'h5555);
    queue_cmd(OP_TICK, 0, 0);           // timer 3 fires, timer 4 reaches zero
    queue_cmd(OP_TICK, 0, 0);           // timer 4 fires

    // Random segments, each under its own mask: all ones, all zeros and A5 in the even ones, random in the odd ones.
    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0: write_isr_mask(8'hFF);
        2: write_isr_mask(8'h00);
        4: write_isr_mask(8'hA5);
        default: write_isr_mask(MASK_W'($urandom_range(255)));
      endcase
      // The sender holds back 38 percent, then 46 percent, then never.
      gap_pct = (seg < 2) ? 38 : ((seg < 4) ? 46 : 0);
      queue_random_items(SEGMENT_ITEMS);
    end

    settle();
    if (mismatch_count == 0 && owed_results.size() == 0) begin
      $display("[countdown_timer_bank] OK");
    end else begin
      $display("[countdown_timer_bank] ERROR");
    end
    $finish;
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin : watchdog
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("[countdown_timer_bank] ERROR");
    $finish;
  end

endmodule
